// File: sv/glyph_outline_3x3_assert.svh
// Assertion macros shared by the outline block.
// Clocked concurrent checks with a synchronous reset that disables them.
`ifndef GLYPH_OUTLINE_3X3_ASSERT_SVH
`define GLYPH_OUTLINE_3X3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/glo_pkg.sv
// Shared types and constants for the glyph outline block.
// No dependencies; the other files that use it refer to it by scoped names.
package glo_pkg;

  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 3 * CHAN_W;
  localparam int CFG_DIM_W = 9;
  localparam int REG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BG_COLOR       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUTLINE_COLOR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUTLINE_ENABLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd4;

  // Position information for one pixel, produced by the raster counters.
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } scan_ctrl_t;

endpackage

// File: sv/glo_if.sv
// Valid/ready stream interfaces for the pixel input and result output.
// Depends on glo_pkg for the channel width.
interface glo_pix_if;
  logic                        valid;
  logic                        ready;
  logic [glo_pkg::CHAN_W-1:0]  red;
  logic [glo_pkg::CHAN_W-1:0]  green;
  logic [glo_pkg::CHAN_W-1:0]  blue;
  logic                        is_filler;

  modport source (output valid, red, green, blue, is_filler, input ready);
  modport sink   (input valid, red, green, blue, is_filler, output ready);
endinterface

interface glo_res_if;
  logic                        valid;
  logic                        ready;
  logic [glo_pkg::CHAN_W-1:0]  out_red;
  logic [glo_pkg::CHAN_W-1:0]  out_green;
  logic [glo_pkg::CHAN_W-1:0]  out_blue;
  logic                        is_outline;
  logic                        last_pixel;

  modport source (output valid, out_red, out_green, out_blue, is_outline, last_pixel,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, is_outline, last_pixel,
                  output ready);
endinterface

// File: sv/glyph_outline_3x3.sv
// One-pixel outline around a glyph bitmap streamed as RGB pixels in raster order.
// Depends on glo_pkg, glo_if, glo_line_ram, glo_raster and the assertion header.
//
// Pixels enter on the pixels channel, one per transfer; results leave on the
// results channel. A background pixel with any non-background neighbour among
// its eight in-image neighbours becomes outline_color, if enabled. The result
// for a pixel is formed once the pixel one row and one column further on has
// been taken, so a result trails its pixel by image_width+1 transfers; after the
// image the source sends image_width+1 filler items to drain it. The final pixel
// carries last_pixel, after which the raster counters restart for the next image.
// Throughput is one pixel per clock while the receiver takes results: the two
// line memories (pixel plus flag, and the flag of the row above) each take one
// access per item. A completed window passes both stages into the result register.
// Reset clears the counters and pipeline and sets configuration to defaults;
// the line memories are not cleared, as no unwritten entry is ever used. When
// the receiver stalls, the result is held and the two pipeline stages keep
// filling, so input is refused only once both stages are occupied.
// Configuration is written through wr_en/wr_index/wr_data; the user must write it only while idle (not enforced).
`include "glyph_outline_3x3_assert.svh"

module glyph_outline_3x3 #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [glo_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [glo_pkg::COLOR_W-1:0]     wr_data,
  glo_pix_if.sink                         pixels,
  glo_res_if.source                       results
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COLOR_W = glo_pkg::COLOR_W;
  localparam int LINE_W  = COLOR_W + 1;

  // Configuration registers.
  logic [COLOR_W-1:0]            bg_color;
  logic [COLOR_W-1:0]            outline_color;
  logic                          outline_enable;
  logic [glo_pkg::CFG_DIM_W-1:0] image_width;
  logic [glo_pkg::CFG_DIM_W-1:0] image_height;

  logic [DIM_W-1:0]  w_eff;
  logic [HDIM_W-1:0] h_eff;

  // Input stage.
  logic               acc;
  logic [COLOR_W-1:0] pix_in;
  logic [COLOR_W-1:0] pix;
  logic               fg;
  logic               fg_d1;
  logic               fg_d2;
  logic [COL_W-1:0]   col;
  glo_pkg::scan_ctrl_t ctrl;

  // First stage: holds the item while the pixel line memory answers.
  logic                v1;
  glo_pkg::scan_ctrl_t s1_ctrl;
  logic [COL_W-1:0]    s1_col;
  logic [2:0]          s1_lo;
  logic [LINE_W-1:0]   a_rd;
  logic                a_fg_d1;
  logic                a_fg_d2;
  logic [COLOR_W-1:0]  a_pix_d1;

  // Second stage: holds the item while the upper flag memory answers.
  logic                v2;
  glo_pkg::scan_ctrl_t s2_ctrl;
  logic [2:0]          s2_lo;
  logic [2:0]          s2_mid;
  logic [2:0]          s2_hi;
  logic [COLOR_W-1:0]  s2_pix;
  logic [0:0]          b_rd;
  logic                b_d1;
  logic                b_d2;

  // Handshake chain.
  logic o_free;
  logic p2;
  logic en2;
  logic p1;
  logic en1;

  logic near;
  logic outl;

  // Result register.
  logic               vo;
  logic [COLOR_W-1:0] res_pix;
  logic               res_outline;
  logic               res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_color       <= '0;
      outline_color  <= '0;
      outline_enable <= 1'b1;
      image_width    <= glo_pkg::CFG_DIM_W'(1);
      image_height   <= glo_pkg::CFG_DIM_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        glo_pkg::REG_BG_COLOR:       bg_color       <= wr_data;
        glo_pkg::REG_OUTLINE_COLOR:  outline_color  <= wr_data;
        glo_pkg::REG_OUTLINE_ENABLE: outline_enable <= wr_data[0];
        glo_pkg::REG_IMAGE_WIDTH:    image_width    <= wr_data[glo_pkg::CFG_DIM_W-1:0];
        glo_pkg::REG_IMAGE_HEIGHT:   image_height   <= wr_data[glo_pkg::CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size acts as one; anything above the maximum acts as the maximum.
  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HDIM_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HDIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = HDIM_W'(image_height);
    end
  end

  always_comb begin
    o_free        = !vo || results.ready;
    p2            = v2 && o_free;
    en2           = !v2 || p2;
    p1            = v1 && en2;
    en1           = !v1 || p1;
    pixels.ready  = en1 && !rst;
    acc           = pixels.valid && pixels.ready;
    pix_in        = {pixels.red, pixels.green, pixels.blue};
    // Filler takes a position and counts as background.
    pix           = pixels.is_filler ? bg_color : pix_in;
    fg            = pix != bg_color;
  end

  glo_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk   (clk),
    .rst   (rst),
    .adv   (acc),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .col   (col),
    .ctrl  (ctrl)
  );

  // Indexed by column, so a read returns the pixel and flag one row back.
  glo_line_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH)
  ) u_pix_ram (
    .clk   (clk),
    .en    (acc),
    .addr  (col),
    .wdata ({fg, pix}),
    .rdata (a_rd)
  );

  // Fed with the flag one row back, so a read returns the flag two rows back.
  glo_line_ram #(
    .DATA_W (1),
    .DEPTH  (MAX_WIDTH)
  ) u_flag_ram (
    .clk   (clk),
    .en    (p1),
    .addr  (s1_col),
    .wdata (a_rd[LINE_W-1]),
    .rdata (b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= acc;
      end
      if (en2) begin
        v2 <= p1;
      end
      if (p2 && s2_ctrl.emit) begin
        vo <= 1'b1;
      end else if (results.ready) begin
        vo <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fg_d1   <= fg;
      fg_d2   <= fg_d1;
      s1_ctrl <= ctrl;
      s1_col  <= col;
      s1_lo   <= {fg_d2, fg_d1, fg};
    end
    if (p1) begin
      s2_ctrl  <= s1_ctrl;
      s2_lo    <= s1_lo;
      s2_mid   <= {a_fg_d2, a_fg_d1, a_rd[LINE_W-1]};
      s2_pix   <= a_pix_d1;
      a_fg_d1  <= a_rd[LINE_W-1];
      a_fg_d2  <= a_fg_d1;
      a_pix_d1 <= a_rd[COLOR_W-1:0];
    end
    if (p2) begin
      b_d1 <= b_rd[0];
      b_d2 <= b_d1;
    end
    if (p2 && s2_ctrl.emit) begin
      res_pix     <= outl ? outline_color : s2_pix;
      res_outline <= outl;
      res_last    <= s2_ctrl.last;
    end
  end

  // Each flag triple is ordered left neighbour, centre column, right neighbour
  // from high bit to low bit; the middle row's centre bit is the pixel itself.
  always_comb begin
    s2_hi = {b_d2, b_d1, b_rd[0]};
    near  = (s2_ctrl.top_ok && s2_ctrl.left_ok && s2_hi[2])
          || (s2_ctrl.top_ok && s2_hi[1])
          || (s2_ctrl.top_ok && s2_ctrl.right_ok && s2_hi[0])
          || (s2_ctrl.left_ok && s2_mid[2])
          || (s2_ctrl.right_ok && s2_mid[0])
          || (s2_ctrl.bot_ok && s2_ctrl.left_ok && s2_lo[2])
          || (s2_ctrl.bot_ok && s2_lo[1])
          || (s2_ctrl.bot_ok && s2_ctrl.right_ok && s2_lo[0]);
    outl  = outline_enable && !s2_mid[1] && near;
  end

  assign results.valid      = vo;
  assign results.out_red    = res_pix[COLOR_W-1 -: glo_pkg::CHAN_W];
  assign results.out_green  = res_pix[glo_pkg::CHAN_W +: glo_pkg::CHAN_W];
  assign results.out_blue   = res_pix[glo_pkg::CHAN_W-1:0];
  assign results.is_outline = res_outline;
  assign results.last_pixel = res_last;

  // A pending result is never dropped while the result register is full.
  `GLO_ASSERT_NEXT(a_emit_held, clk, rst, v2 && s2_ctrl.emit && !o_free, v2 && s2_ctrl.emit, "pending result lost under stall")
  // Counters restart after the final pixel, so the next item starts a new image.
  `GLO_ASSERT_NEXT(a_restart, clk, rst, acc && ctrl.last, !ctrl.emit, "raster counters did not restart after the final pixel")

endmodule

// File: sv/glo_line_ram.sv
// Single-port line memory, read-before-write, registered read data.
// No dependencies.
module glo_line_ram #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = 4,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // The read returns the entry as it stood before this write.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// File: sv/glo_raster.sv
// Raster position counters for the incoming and the emitted pixel.
// Depends on glo_pkg for the position struct.
module glo_raster #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1),
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [DIM_W-1:0]    w_eff,
  input  logic [HDIM_W-1:0]   h_eff,
  output logic [COL_W-1:0]    col,
  output glo_pkg::scan_ctrl_t ctrl
);

  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int CW    = DIM_W + 1;
  localparam int RCW   = ROW_W + 1;

  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  out_col;
  logic [HDIM_W-1:0] out_row;

  logic in_col_end;
  logic out_col_end;
  logic out_row_end;

  always_comb begin
    in_col_end    = (CW'(in_col) + CW'(1)) >= CW'(w_eff);
    out_col_end   = (CW'(out_col) + CW'(1)) >= CW'(w_eff);
    out_row_end   = (RCW'(out_row) + RCW'(1)) >= RCW'(h_eff);
    // A result leaves once the window below the centre pixel has arrived.
    ctrl.emit     = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
    ctrl.last     = ctrl.emit && out_row_end && out_col_end;
    ctrl.top_ok   = out_row != '0;
    ctrl.bot_ok   = !out_row_end;
    ctrl.left_ok  = out_col != '0;
    ctrl.right_ok = !out_col_end;
    col           = in_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (adv) begin
      if (ctrl.last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_col_end) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (ctrl.emit) begin
          if (out_col_end) begin
            out_col <= '0;
            out_row <= out_row + HDIM_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: test/glyph_outline_3x3_tb.sv
// Self-checking testbench for glyph_outline_3x3: directed rows, then random glyph images.
// Depends on glo_pkg, the glo_pix_if/glo_res_if interfaces and the outline block itself.
`timescale 1ns / 1ps

module glyph_outline_3x3_tb;

  localparam int MAX_W      = 256;
  localparam int MAX_H      = 256;
  localparam int DLY_DEPTH  = MAX_W + 1;
  localparam int RING_DEPTH = 2 * MAX_W + 2;
  localparam int SETTLE     = 16;
  localparam int HOLD_LEN   = 200;
  localparam int QUIET_MAX  = 2000;

  typedef struct packed {
    logic [glo_pkg::CHAN_W-1:0] red;
    logic [glo_pkg::CHAN_W-1:0] green;
    logic [glo_pkg::CHAN_W-1:0] blue;
    logic                       is_outline;
    logic                       last_pixel;
  } shaded_px_t;

  typedef enum logic {ROW_PIX, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [glo_pkg::REG_IDX_W-1:0] idx;
    logic [glo_pkg::COLOR_W-1:0]   value;
    logic                          filler;
    logic                          has_exp;
    shaded_px_t                    exp;
  } stim_row_t;

  localparam shaded_px_t NO_RESULT = '0;

  logic clk;
  logic rst;
  logic wr_en;
  logic [glo_pkg::REG_IDX_W-1:0] wr_index;
  logic [glo_pkg::COLOR_W-1:0]   wr_data;

  glo_pix_if pix_ch ();
  glo_res_if res_ch ();

  glyph_outline_3x3 uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixels   (pix_ch.sink),
    .results  (res_ch.source)
  );

  // Predictor state: configuration copy, line stores and raster counters.
  logic [glo_pkg::COLOR_W-1:0]   cfg_bg;
  logic [glo_pkg::COLOR_W-1:0]   cfg_outline;
  logic                          cfg_enable;
  logic [glo_pkg::CFG_DIM_W-1:0] cfg_width;
  logic [glo_pkg::CFG_DIM_W-1:0] cfg_height;
  logic [glo_pkg::COLOR_W-1:0]   delay_line [DLY_DEPTH];
  bit                            fg_ring [RING_DEPTH];
  int in_col, in_row, out_col, out_row, dly_ptr, ring_ptr;

  shaded_px_t awaited_px[$];
  stim_row_t  stim[$];

  int  mismatches;
  int  results_seen;
  int  outlines_seen;
  int  pixels_sent;
  int  base_sent;
  int  images_sent;
  int  quiet_cycles;
  int  hold_count;
  int  send_idle;
  int  recv_idle;
  bit  hold_req;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int dim_limit(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Advances the predictor by one accepted item; returns 1 when a pixel leaves.
  function automatic bit predict_outline(input logic [glo_pkg::COLOR_W-1:0] px_in,
                                         input bit filler, output shaded_px_t res);
    int w, h, dlen, rlen, r, c, d, dy, dx, cslot, slot;
    logic [glo_pkg::COLOR_W-1:0] px, held;
    bit fg, emit, near, outl, last;
    w = dim_limit(int'(cfg_width), MAX_W);
    h = dim_limit(int'(cfg_height), MAX_H);
    dlen = w + 1;
    rlen = 2 * w + 2;
    if (dly_ptr >= dlen) dly_ptr = 0;
    if (ring_ptr >= rlen) ring_ptr = 0;
    px = filler ? cfg_bg : px_in;
    fg = (px != cfg_bg);
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    last = 1'b0;
    res = NO_RESULT;
    if (emit) begin
      held = delay_line[dly_ptr];
      cslot = (ring_ptr + rlen - dlen) % rlen;
      near = 1'b0;
      r = out_row;
      c = out_col;
      for (dy = -1; dy <= 1; dy++) begin
        for (dx = -1; dx <= 1; dx++) begin
          if (!(dx == 0 && dy == 0) && r + dy >= 0 && r + dy < h &&
              c + dx >= 0 && c + dx < w) begin
            d = dy * w + dx;
            // The bottom-right neighbour is the pixel arriving in this transfer.
            if (d == dlen) begin
              near |= fg;
            end else begin
              slot = (ring_ptr + rlen - dlen + d) % rlen;
              near |= fg_ring[slot];
            end
          end
        end
      end
      outl = cfg_enable && !fg_ring[cslot] && near;
      if (outl) held = cfg_outline;
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res = '{held[23:16], held[15:8], held[7:0], outl, last};
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
    delay_line[dly_ptr] = px;
    fg_ring[ring_ptr] = fg;
    dly_ptr = (dly_ptr + 1 >= dlen) ? 0 : dly_ptr + 1;
    ring_ptr = (ring_ptr + 1 >= rlen) ? 0 : ring_ptr + 1;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      dly_ptr = 0;
      ring_ptr = 0;
    end
    return emit;
  endfunction

  function automatic shaded_px_t px_exp(input logic [glo_pkg::COLOR_W-1:0] c, input bit o,
                                        input bit l);
    return '{c[23:16], c[15:8], c[7:0], o, l};
  endfunction

  function automatic stim_row_t pix_row(input logic [glo_pkg::COLOR_W-1:0] value,
                                        input bit filler, input bit has_exp,
                                        input shaded_px_t exp);
    return '{ROW_PIX, glo_pkg::REG_BG_COLOR, value, filler, has_exp, exp};
  endfunction

  function automatic stim_row_t reg_row(input logic [glo_pkg::REG_IDX_W-1:0] idx,
                                        input logic [glo_pkg::COLOR_W-1:0] value);
    return '{ROW_REG, idx, value, 1'b0, 1'b0, NO_RESULT};
  endfunction

  function automatic logic [glo_pkg::COLOR_W-1:0] pick_colour();
    case ($urandom_range(3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return glo_pkg::COLOR_W'($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (awaited_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves wr_en high; the caller lowers it after the last write of a group.
  task automatic put_reg(input logic [glo_pkg::REG_IDX_W-1:0] idx,
                         input logic [glo_pkg::COLOR_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      glo_pkg::REG_BG_COLOR:       cfg_bg = data;
      glo_pkg::REG_OUTLINE_COLOR:  cfg_outline = data;
      glo_pkg::REG_OUTLINE_ENABLE: cfg_enable = data[0];
      glo_pkg::REG_IMAGE_WIDTH:    cfg_width = data[glo_pkg::CFG_DIM_W-1:0];
      glo_pkg::REG_IMAGE_HEIGHT:   cfg_height = data[glo_pkg::CFG_DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [glo_pkg::COLOR_W-1:0] value, input bit filler,
                            input bit use_typed, input shaded_px_t typed);
    int gap;
    shaded_px_t pred;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle) gap++;
    // Now and then the source stops until every pending result has come out.
    if ($urandom_range(199) == 0) begin
      pix_ch.valid <= 1'b0;
      wait_drained();
    end
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.red       <= value[23:16];
    pix_ch.green     <= value[15:8];
    pix_ch.blue      <= value[7:0];
    pix_ch.is_filler <= filler;
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
    if (predict_outline(value, filler, pred))
      awaited_px.push_back(use_typed ? typed : pred);
  endtask

  // One whole image with random colours, followed by its drain items.
  task automatic run_image(input int w_cfg, input int h_cfg);
    int n, k;
    logic [glo_pkg::COLOR_W-1:0] px;
    pix_ch.valid <= 1'b0;
    wait_drained();
    put_reg(glo_pkg::REG_BG_COLOR, pick_colour());
    put_reg(glo_pkg::REG_OUTLINE_COLOR, pick_colour());
    put_reg(glo_pkg::REG_OUTLINE_ENABLE, glo_pkg::COLOR_W'($urandom_range(4) != 0));
    put_reg(glo_pkg::REG_IMAGE_WIDTH, glo_pkg::COLOR_W'(w_cfg));
    put_reg(glo_pkg::REG_IMAGE_HEIGHT, glo_pkg::COLOR_W'(h_cfg));
    wr_en <= 1'b0;
    n = dim_limit(w_cfg, MAX_W) * dim_limit(h_cfg, MAX_H);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 5)       send_pixel(cfg_bg, 1'b1, 1'b0, NO_RESULT);
      else if (k < 55) send_pixel(cfg_bg, 1'b0, 1'b0, NO_RESULT);
      else if (k < 65) send_pixel(cfg_outline, 1'b0, 1'b0, NO_RESULT);
      else begin
        px = glo_pkg::COLOR_W'($urandom());
        send_pixel(px, 1'b0, 1'b0, NO_RESULT);
      end
    end
    for (int i = 0; i <= dim_limit(w_cfg, MAX_W); i++) begin
      px = glo_pkg::COLOR_W'($urandom());
      send_pixel(px, ($urandom_range(9) < 7), 1'b0, NO_RESULT);
    end
    images_sent++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    shaded_px_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.is_outline) outlines_seen++;
      if (awaited_px.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual %02h%02h%02h", $time,
                 res_ch.out_red, res_ch.out_green, res_ch.out_blue);
      end else begin
        want = awaited_px.pop_front();
        check_field("out_red", want.red, res_ch.out_red);
        check_field("out_green", want.green, res_ch.out_green);
        check_field("out_blue", want.blue, res_ch.out_blue);
        check_field("is_outline", want.is_outline, res_ch.is_outline);
        check_field("last_pixel", want.last_pixel, res_ch.last_pixel);
      end
    end
    // A single long stall lets the block fill up and refuse input.
    if (hold_req && hold_count < HOLD_LEN) begin
      res_ch.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             QUIET_MAX, awaited_px.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = glo_pkg::REG_BG_COLOR;
    wr_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.red = '0;
    pix_ch.green = '0;
    pix_ch.blue = '0;
    pix_ch.is_filler = 1'b0;
    res_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    outlines_seen = 0;
    pixels_sent = 0;
    base_sent = 0;
    images_sent = 0;
    quiet_cycles = 0;
    hold_count = 0;
    hold_req = 1'b0;
    send_idle = 32;
    recv_idle = 77;
    cfg_bg = '0;
    cfg_outline = '0;
    cfg_enable = 1'b1;
    cfg_width = 9'd1;
    cfg_height = 9'd1;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    dly_ptr = 0;
    ring_ptr = 0;
    foreach (delay_line[i]) delay_line[i] = '0;
    foreach (fg_ring[i]) fg_ring[i] = 1'b0;

    // 1x1 image at reset geometry; a real pixel in the drain phase counts as filler.
    stim.push_back(pix_row(24'hFFFFFF, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h123456, 1'b0, 1'b1, px_exp(24'hFFFFFF, 1'b0, 1'b1)));
    // 3x3 image with one foreground pixel in the centre: the ring around it is outlined.
    stim.push_back(reg_row(glo_pkg::REG_BG_COLOR, 24'h000000));
    stim.push_back(reg_row(glo_pkg::REG_OUTLINE_COLOR, 24'h00FF00));
    stim.push_back(reg_row(glo_pkg::REG_OUTLINE_ENABLE, 24'd1));
    stim.push_back(reg_row(glo_pkg::REG_IMAGE_WIDTH, 24'd3));
    stim.push_back(reg_row(glo_pkg::REG_IMAGE_HEIGHT, 24'd3));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'hFFFFFF, 1'b1, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'hFFFFFF, 1'b0, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b1, px_exp(24'hFFFFFF, 1'b0, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'hABCDEF, 1'b0, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b1, px_exp(24'h00FF00, 1'b1, 1'b1)));
    // Outlining disabled: a background pixel beside a foreground one passes unchanged.
    stim.push_back(reg_row(glo_pkg::REG_OUTLINE_ENABLE, 24'd0));
    stim.push_back(reg_row(glo_pkg::REG_IMAGE_WIDTH, 24'd2));
    stim.push_back(reg_row(glo_pkg::REG_IMAGE_HEIGHT, 24'd1));
    stim.push_back(pix_row(24'h000000, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'hFF00FF, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b1, px_exp(24'h000000, 1'b0, 1'b0)));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b1, px_exp(24'hFF00FF, 1'b0, 1'b1)));
    // Zero geometry behaves as a single pixel.
    stim.push_back(reg_row(glo_pkg::REG_IMAGE_WIDTH, 24'd0));
    stim.push_back(reg_row(glo_pkg::REG_IMAGE_HEIGHT, 24'd0));
    stim.push_back(pix_row(24'h7E7E7E, 1'b0, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b0, NO_RESULT));
    stim.push_back(pix_row(24'h000000, 1'b1, 1'b1, px_exp(24'h7E7E7E, 1'b0, 1'b1)));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < stim.size(); i++) begin
      if (stim[i].kind == ROW_REG) begin
        if (i == 0 || stim[i-1].kind != ROW_REG) begin
          pix_ch.valid <= 1'b0;
          wait_drained();
        end
        put_reg(stim[i].idx, stim[i].value);
        if (i + 1 == stim.size() || stim[i+1].kind != ROW_REG) wr_en <= 1'b0;
      end else begin
        send_pixel(stim[i].value, stim[i].filler, stim[i].has_exp, stim[i].exp);
      end
    end
    base_sent = pixels_sent;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 32; recv_idle <= 77; end
        1: begin send_idle = 77; recv_idle <= 32; end
        default: begin
          send_idle = 0;
          recv_idle <= 0;
          // The long stall starts only once the previous image has fully drained.
          pix_ch.valid <= 1'b0;
          wait_drained();
          hold_req <= 1'b1;
          run_image(8, 6);
        end
      endcase
      while (pixels_sent < base_sent + 40 * (phase + 1))
        run_image($urandom_range(1, 8), $urandom_range(1, 6));
    end
    // Geometry extremes: zero size, and a width beyond the supported maximum.
    run_image(0, 0);
    run_image(511, 1);

    pix_ch.valid <= 1'b0;
    wait_drained();
    $display("Sent %0d pixel transfers over %0d random images plus directed rows;",
             pixels_sent, images_sent);
    $display("checked %0d results, %0d of them outlined.", results_seen, outlines_seen);
    if (mismatches == 0 && awaited_px.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
